### src/bpu_pkg.sv
`timescale 1ns / 1ps

package bpu_pkg;

	// Widths of the pixel word and of one output component.
	localparam int unsigned PIXEL_W = 32;
	localparam int unsigned COMP_W  = 8;
	localparam int unsigned SHIFT_W = $clog2(PIXEL_W);
	localparam int unsigned WIDTH_W = $clog2(PIXEL_W + 1);
	localparam int unsigned COUNT_W = 3;
	localparam int unsigned INDEX_W = 3;

	// Packed output word: count, red, green, blue, alpha, padded to bytes.
	localparam int unsigned OUT_BITS = COUNT_W + 4 * COMP_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Configuration register indexes.
	typedef enum logic [INDEX_W-1:0] {
		REG_RED_MASK      = 3'd0,
		REG_GREEN_MASK    = 3'd1,
		REG_BLUE_MASK     = 3'd2,
		REG_ALPHA_MASK    = 3'd3,
		REG_BYTES_PER_PIX = 3'd4,
		REG_ALPHA_PRESENT = 3'd5
	} reg_index_t;

	// Component counts.
	localparam logic [COUNT_W-1:0] COUNT_R    = 3'd1;
	localparam logic [COUNT_W-1:0] COUNT_RG   = 3'd2;
	localparam logic [COUNT_W-1:0] COUNT_RGB  = 3'd3;
	localparam logic [COUNT_W-1:0] COUNT_RGBA = 3'd4;

	// Settings of one color channel, with its mask already analyzed.
	typedef struct packed {
		logic [PIXEL_W-1:0] mask;
		logic [SHIFT_W-1:0] shift;
		logic [WIDTH_W-1:0] width;
	} chan_cfg_t;

	// Everything the datapath needs from the configuration side.
	typedef struct packed {
		chan_cfg_t          red;
		chan_cfg_t          green;
		chan_cfg_t          blue;
		chan_cfg_t          alpha;
		logic [PIXEL_W-1:0] byte_mask;
		logic [COUNT_W-1:0] count;
	} unpack_cfg_t;

	// Index of the lowest set bit; zero for an empty word.
	function automatic logic [SHIFT_W-1:0] trailing_zeros(logic [PIXEL_W-1:0] v);
		logic [SHIFT_W-1:0] n;
		n = '0;
		for (int i = PIXEL_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				n = SHIFT_W'(i);
			end
		end
		return n;
	endfunction

	// Widen a field of b bits to 8 bits by repeating its pattern downward,
	// or keep the top 8 bits of a wider field. Each pass places one copy.
	function automatic logic [COMP_W-1:0] widen8(logic [PIXEL_W-1:0] v,
			logic [WIDTH_W-1:0] b);
		logic [COMP_W-1:0] acc;
		logic signed [9:0] room;
		logic signed [9:0] bs;
		logic signed [9:0] s;
		logic [SHIFT_W-1:0] rsh;
		logic [2:0] lsh;
		acc  = '0;
		room = 10'sd8;
		bs   = signed'(10'(b));
		s    = '0;
		rsh  = '0;
		lsh  = '0;
		for (int k = 0; k < COMP_W; k++) begin
			if (b != '0 && room > 10'sd0) begin
				s = room - bs;
				if (s >= 10'sd0) begin
					lsh = 3'(s);
					acc = acc | (v[COMP_W-1:0] << lsh);
				end else begin
					rsh = SHIFT_W'(-s);
					acc = acc | COMP_W'(v >> rsh);
				end
				room = s;
			end
		end
		return acc;
	endfunction

endpackage

### src/bitmask_pixel_unpack_rgba8.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  tdata[31:0] pixel_word
// m_*      out        m_tvalid/m_tready  tdata: count, red, green, blue, alpha
// cfg_*    in         cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One pixel per clock sustained while m_tready stays high; a result is valid
// once it has passed the input register, then the result register.
// The mask analysis is registered in the cycle after a configuration write.
// Reset clears the valid flags and the configuration to its reset values.
// A stalled output holds its result; the input register still takes a pixel
// while the result waits, and input ready drops only when both are full.

module bitmask_pixel_unpack_rgba8
	import bpu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PIXEL_W-1:0] s_tdata,   // [31:0] pixel_word
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,   // [2:0] component_count, [10:3] comp_red,
	                                      // [18:11] comp_green, [26:19] comp_blue,
	                                      // [34:27] comp_alpha, rest zero
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [PIXEL_W-1:0] cfg_data
);

	unpack_cfg_t         cfg;
	logic                valid_s1;
	logic [PIXEL_W-1:0]  pixel_s1;
	logic                valid_s2;
	logic [OUT_BITS-1:0] result_s2;
	logic                adv_s2;
	logic                adv_s1;
	logic [PIXEL_W-1:0]  pixel;
	logic [COMP_W-1:0]   red;
	logic [COMP_W-1:0]   green;
	logic [COMP_W-1:0]   blue;
	logic [COMP_W-1:0]   alpha;
	logic [COMP_W-1:0]   green_out;
	logic [COMP_W-1:0]   blue_out;
	logic [COMP_W-1:0]   alpha_out;

	assign cfg_ready = 1'b1;

	bpu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Pipeline flow control.
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign adv_s1   = s_tvalid && s_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pixel_s1 <= s_tdata;
		end
	end

	// Drop the bytes above the pixel size, then extract each channel.
	assign pixel = pixel_s1 & cfg.byte_mask;

	bpu_field u_red   (.pixel(pixel), .chan(cfg.red),   .comp(red));
	bpu_field u_green (.pixel(pixel), .chan(cfg.green), .comp(green));
	bpu_field u_blue  (.pixel(pixel), .chan(cfg.blue),  .comp(blue));
	bpu_field u_alpha (.pixel(pixel), .chan(cfg.alpha), .comp(alpha));

	// Components outside the count read as zero.
	assign green_out = (cfg.count >= COUNT_RG)   ? green : '0;
	assign blue_out  = (cfg.count >= COUNT_RGB)  ? blue  : '0;
	assign alpha_out = (cfg.count >= COUNT_RGBA) ? alpha : '0;

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= {alpha_out, blue_out, green_out, red, cfg.count};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'(result_s2);

endmodule

### src/bpu_cfg.sv
`timescale 1ns / 1ps

module bpu_cfg
	import bpu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [INDEX_W-1:0]        wr_index,
	input  logic [PIXEL_W-1:0]        wr_data,
	output unpack_cfg_t               cfg
);

	logic [PIXEL_W-1:0] red_mask_q;
	logic [PIXEL_W-1:0] green_mask_q;
	logic [PIXEL_W-1:0] blue_mask_q;
	logic [PIXEL_W-1:0] alpha_mask_q;
	logic [2:0]         bytes_per_pixel_q;
	logic               alpha_present_q;
	unpack_cfg_t        cfg_d;
	unpack_cfg_t        cfg_q;

	// Register file; writes to indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_mask_q        <= '0;
			green_mask_q      <= '0;
			blue_mask_q       <= '0;
			alpha_mask_q      <= '0;
			bytes_per_pixel_q <= 3'd4;
			alpha_present_q   <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_RED_MASK:      red_mask_q        <= wr_data;
				REG_GREEN_MASK:    green_mask_q      <= wr_data;
				REG_BLUE_MASK:     blue_mask_q       <= wr_data;
				REG_ALPHA_MASK:    alpha_mask_q      <= wr_data;
				REG_BYTES_PER_PIX: bytes_per_pixel_q <= wr_data[2:0];
				REG_ALPHA_PRESENT: alpha_present_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Analyze the masks: shift is the trailing-zero count, width the bit count.
	always_comb begin
		cfg_d.red.mask    = red_mask_q;
		cfg_d.red.shift   = trailing_zeros(red_mask_q);
		cfg_d.red.width   = WIDTH_W'($countones(red_mask_q));
		cfg_d.green.mask  = green_mask_q;
		cfg_d.green.shift = trailing_zeros(green_mask_q);
		cfg_d.green.width = WIDTH_W'($countones(green_mask_q));
		cfg_d.blue.mask   = blue_mask_q;
		cfg_d.blue.shift  = trailing_zeros(blue_mask_q);
		cfg_d.blue.width  = WIDTH_W'($countones(blue_mask_q));
		cfg_d.alpha.mask  = alpha_mask_q;
		cfg_d.alpha.shift = trailing_zeros(alpha_mask_q);
		cfg_d.alpha.width = WIDTH_W'($countones(alpha_mask_q));

		// A byte count of zero acts as one, five and above as four.
		case (bytes_per_pixel_q)
			3'd0, 3'd1: cfg_d.byte_mask = 32'h0000_00FF;
			3'd2:       cfg_d.byte_mask = 32'h0000_FFFF;
			3'd3:       cfg_d.byte_mask = 32'h00FF_FFFF;
			default:    cfg_d.byte_mask = 32'hFFFF_FFFF;
		endcase

		if (red_mask_q != '0 && green_mask_q != '0 && blue_mask_q != '0) begin
			cfg_d.count = alpha_present_q ? COUNT_RGBA : COUNT_RGB;
		end else if (red_mask_q != '0 && green_mask_q != '0) begin
			cfg_d.count = COUNT_RG;
		end else begin
			cfg_d.count = COUNT_R;
		end
	end

	// The analyzed settings are registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	assign cfg = cfg_q;

endmodule

### src/bpu_field.sv
`timescale 1ns / 1ps

module bpu_field
	import bpu_pkg::*;
(
	input  logic [PIXEL_W-1:0] pixel,
	input  chan_cfg_t          chan,
	output logic [COMP_W-1:0]  comp
);

	logic [PIXEL_W-1:0] field;

	// Isolate the field, align it to bit zero, then scale it to 8 bits.
	always_comb begin
		field = (pixel & chan.mask) >> chan.shift;
		comp  = widen8(field, chan.width);
	end

endmodule

### tb/sv/bitmask_pixel_unpack_rgba8_tb.sv
`timescale 1ns / 1ps

module bitmask_pixel_unpack_rgba8_tb;
	import bpu_pkg::*;

	// Register indexes past the end of the register list; writes there are dropped.
	localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

	// Bit positions of the result fields inside m_tdata.
	localparam int unsigned RED_LO   = COUNT_W;
	localparam int unsigned GREEN_LO = RED_LO + COMP_W;
	localparam int unsigned BLUE_LO  = GREEN_LO + COMP_W;
	localparam int unsigned ALPHA_LO = BLUE_LO + COMP_W;

	localparam int unsigned LONG_HOLD = 80;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [COMP_W-1:0]  red;
		logic [COMP_W-1:0]  green;
		logic [COMP_W-1:0]  blue;
		logic [COMP_W-1:0]  alpha;
	} rgba_comp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [PIXEL_W-1:0] s_tdata = '0;   // [31:0] pixel_word
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;        // [2:0] count, [10:3] red, [18:11] green,
	                                    // [26:19] blue, [34:27] alpha
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [INDEX_W-1:0] cfg_index = '0;
	logic [PIXEL_W-1:0] cfg_data = '0;

	// Shadow copy of the pixel format registers, at their reset values.
	logic [PIXEL_W-1:0] fmt_red_mask   = '0;
	logic [PIXEL_W-1:0] fmt_green_mask = '0;
	logic [PIXEL_W-1:0] fmt_blue_mask  = '0;
	logic [PIXEL_W-1:0] fmt_alpha_mask = '0;
	logic [2:0]         fmt_bytes      = 3'd4;
	logic               fmt_alpha_on   = 1'b0;

	logic [PIXEL_W-1:0] pixel_feed_q[$];
	rgba_comp_t         comp_due_q[$];

	int unsigned send_idle_pct = 27;
	int unsigned recv_idle_pct = 64;
	int unsigned hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned err_count = 0;
	logic        pixel_taken = 1'b0;

	bitmask_pixel_unpack_rgba8 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Widen a field by repeating its pattern downward, or keep its top 8 bits.
	function automatic logic [COMP_W-1:0] widen_field(logic [PIXEL_W-1:0] v,
			int unsigned bits);
		logic [PIXEL_W-1:0] acc;
		int unsigned room;
		acc  = '0;
		room = COMP_W;
		if (bits == 0) begin
			return '0;
		end
		while (bits < room) begin
			acc  = acc | (v << (room - bits));
			room = room - bits;
		end
		acc = acc | (v >> (bits - room));
		return acc[COMP_W-1:0];
	endfunction

	// Pull one channel out of the pixel: AND with the mask, shift down, widen.
	function automatic logic [COMP_W-1:0] channel_value(logic [PIXEL_W-1:0] pixel,
			logic [PIXEL_W-1:0] mask);
		int unsigned lsb;
		int unsigned ones;
		lsb  = 0;
		ones = 0;
		for (int i = PIXEL_W - 1; i >= 0; i--) begin
			if (mask[i]) begin
				lsb = i;
				ones++;
			end
		end
		return widen_field((pixel & mask) >> lsb, ones);
	endfunction

	// Components the block should produce for one pixel under the current format.
	function automatic rgba_comp_t unpack_pixel(logic [PIXEL_W-1:0] raw);
		rgba_comp_t  res;
		int unsigned nbytes;
		logic [PIXEL_W-1:0] pixel;
		res    = '0;
		nbytes = fmt_bytes;
		pixel  = raw;
		if (nbytes == 0) begin
			nbytes = 1;
		end
		if (nbytes > 4) begin
			nbytes = 4;
		end
		if (nbytes < 4) begin
			pixel = pixel & ((32'h1 << (nbytes * 8)) - 32'h1);
		end
		if (fmt_red_mask != '0 && fmt_green_mask != '0 && fmt_blue_mask != '0) begin
			res.count = fmt_alpha_on ? COUNT_RGBA : COUNT_RGB;
		end else if (fmt_red_mask != '0 && fmt_green_mask != '0) begin
			res.count = COUNT_RG;
		end else begin
			res.count = COUNT_R;
		end
		res.red = channel_value(pixel, fmt_red_mask);
		if (res.count >= COUNT_RG) begin
			res.green = channel_value(pixel, fmt_green_mask);
		end
		if (res.count >= COUNT_RGB) begin
			res.blue = channel_value(pixel, fmt_blue_mask);
		end
		if (res.count >= COUNT_RGBA) begin
			res.alpha = channel_value(pixel, fmt_alpha_mask);
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [COMP_W-1:0] want,
			input logic [COMP_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_count++;
		end
	endtask

	// Pixel driver: holds an offered pixel until its transfer, idles at random.
	always @(negedge clk) begin
		if (s_tvalid && !pixel_taken) begin
			s_tvalid <= 1'b1;
		end else if (arst_n && pixel_feed_q.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			s_tvalid <= 1'b1;
			s_tdata  <= pixel_feed_q[0];
		end else begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
		end
	end

	// Result ready: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor: predict on each pixel transfer, compare on each result transfer.
	always @(posedge clk) begin
		rgba_comp_t want;
		pixel_taken = s_tvalid && s_tready;
		if (pixel_taken) begin
			comp_due_q.push_back(unpack_pixel(s_tdata));
			void'(pixel_feed_q.pop_front());
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (comp_due_q.size() == 0) begin
				$error("result transfer with no pixel outstanding: m_tdata %h", m_tdata);
				err_count++;
			end else begin
				want = comp_due_q.pop_front();
				check_field("component_count", COMP_W'(want.count),
					COMP_W'(m_tdata[COUNT_W-1:0]));
				check_field("comp_red", want.red, m_tdata[RED_LO +: COMP_W]);
				check_field("comp_green", want.green, m_tdata[GREEN_LO +: COMP_W]);
				check_field("comp_blue", want.blue, m_tdata[BLUE_LO +: COMP_W]);
				check_field("comp_alpha", want.alpha, m_tdata[ALPHA_LO +: COMP_W]);
			end
		end
	end

	// Wait at a falling edge until every pixel went out and every result came back.
	task automatic wait_drained();
		@(negedge clk);
		while (pixel_feed_q.size() != 0 || comp_due_q.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
	endtask

	// One register write transfer; leaves cfg_valid high for a following write.
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [PIXEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_RED_MASK:      fmt_red_mask   = val;
			REG_GREEN_MASK:    fmt_green_mask = val;
			REG_BLUE_MASK:     fmt_blue_mask  = val;
			REG_ALPHA_MASK:    fmt_alpha_mask = val;
			REG_BYTES_PER_PIX: fmt_bytes      = val[2:0];
			REG_ALPHA_PRESENT: fmt_alpha_on   = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Reprogram the whole pixel format once the block has gone idle.
	task automatic set_format(input logic [PIXEL_W-1:0] r, input logic [PIXEL_W-1:0] g,
			input logic [PIXEL_W-1:0] b, input logic [PIXEL_W-1:0] a,
			input logic [2:0] bpp, input logic alpha_on);
		wait_drained();
		repeat (6) @(negedge clk);
		write_reg(REG_RED_MASK, r);
		write_reg(REG_GREEN_MASK, g);
		write_reg(REG_BLUE_MASK, b);
		write_reg(REG_ALPHA_MASK, a);
		write_reg(REG_BYTES_PER_PIX, {$urandom_range(0, 1) ? 29'($urandom) : 29'h0, bpp});
		write_reg(REG_ALPHA_PRESENT, {$urandom_range(0, 1) ? 31'($urandom) : 31'h0,
			alpha_on});
		write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
		cfg_valid <= 1'b0;
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [PIXEL_W-1:0] random_mask();
		logic [63:0] ones;
		int unsigned pick;
		pick = $urandom_range(0, 9);
		ones = (64'h1 << $urandom_range(1, 16)) - 64'h1;
		case (pick)
			0: return '0;
			1: return $urandom;
			2: return '1;
			default: return PIXEL_W'(ones << $urandom_range(0, 31));
		endcase
	endfunction

	task automatic push_random(input int unsigned n);
		for (int i = 0; i < n; i++) begin
			pixel_feed_q.push_back($urandom);
		end
	endtask

	// Directed formats, then random formats under three idling regimes.
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// Reset format: all masks empty, so only a zero red component.
		pixel_feed_q.push_back(32'hFFFF_FFFF);
		pixel_feed_q.push_back(32'h0000_0000);

		// Plain 32-bit RGBA with alpha.
		set_format(32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000, 3'd4, 1'b1);
		pixel_feed_q.push_back(32'h0000_0000);
		pixel_feed_q.push_back(32'hFFFF_FFFF);
		pixel_feed_q.push_back(32'h1234_5678);
		pixel_feed_q.push_back(32'h8000_0001);

		// 16-bit 565 with stale upper bytes that must be dropped.
		set_format(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h0000_0000, 3'd2, 1'b0);
		pixel_feed_q.push_back(32'hA5A5_FFFF);
		pixel_feed_q.push_back(32'hFFFF_0000);
		pixel_feed_q.push_back(32'h0000_8421);

		// 1555 with a one-bit alpha field.
		set_format(32'h0000_7C00, 32'h0000_03E0, 32'h0000_001F, 32'h0000_8000, 3'd2, 1'b1);
		pixel_feed_q.push_back(32'h0000_8000);
		pixel_feed_q.push_back(32'h0000_7FFF);

		// Two components only; alpha mask set but unused, byte count zero acts as one.
		set_format(32'h0000_000F, 32'h0000_00F0, 32'h0000_0000, 32'h0000_0F00, 3'd0, 1'b1);
		pixel_feed_q.push_back(32'hFFFF_FF5A);
		pixel_feed_q.push_back(32'h0000_00C3);

		// Red missing: one component reading zero while green and blue are set.
		set_format(32'h0000_0000, 32'h0000_FF00, 32'h00FF_0000, 32'hFF00_0000, 3'd4, 1'b1);
		pixel_feed_q.push_back(32'hFFFF_FFFF);

		// Non-contiguous masks, full-width mask, wide field, byte count past the top.
		set_format(32'h0000_0005, 32'h8000_0001, 32'hF0F0_0000, 32'hFFFF_FFFF, 3'd7, 1'b1);
		pixel_feed_q.push_back(32'hFFFF_FFFF);
		pixel_feed_q.push_back(32'h9050_0005);
		pixel_feed_q.push_back(32'h7FFF_FFFE);

		set_format(32'h00FF_F000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0FFE, 3'd5, 1'b0);
		pixel_feed_q.push_back(32'h00AB_C000);
		pixel_feed_q.push_back(32'h8000_0001);
		pixel_feed_q.push_back(32'h7F00_0FFE);

		// Three-byte pixels.
		set_format(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, 3'd3, 1'b1);
		pixel_feed_q.push_back(32'hFF80_40C0);
		pixel_feed_q.push_back(32'h0012_3456);

		// Random formats, 64 pixels each, under each idling regime.
		for (int mode = 0; mode < 3; mode++) begin
			wait_drained();
			send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 64 : 0;
			recv_idle_pct = (mode == 0) ? 64 : (mode == 1) ? 27 : 0;
			for (int k = 0; k < 8; k++) begin
				set_format(random_mask(), random_mask(), random_mask(), random_mask(),
					($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4)),
					1'($urandom));
				push_random(64);
				if (k == 2) begin
					// Long output stall while pixels keep coming, to fill the block.
					hold_req = hold_req + 1;
				end
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### bitmask_pixel_unpack_rgba8.f
src/bpu_pkg.sv
src/bpu_cfg.sv
src/bpu_field.sv
src/bitmask_pixel_unpack_rgba8.sv
tb/sv/bitmask_pixel_unpack_rgba8_tb.sv
